[rtl/trpd_pkg.sv]
// ============================================================================
// trpd_pkg - shared types and constants of the run-length pixel decoder
// Holds the pixel record passed from the parser to the counter stage, the
// register indexes and the fixed packet constants.
// ============================================================================
package trpd_pkg;

   localparam int unsigned FIFO_DEPTH = 2;

   // Packet header split point and run bias
   localparam logic [7:0] RUN_FLAG_HDR = 8'd128;
   localparam logic [7:0] RUN_BIAS     = 8'd127;

   localparam logic [2:0] BPP_FOUR     = 3'd4;

   typedef enum logic [1:0] {
      REG_BYTES_PER_PIXEL = 2'd0,
      REG_RLE_MODE        = 2'd1,
      REG_PIXEL_TOTAL     = 2'd2,
      REG_UNUSED          = 2'd3
   } reg_index_type;

   // One decoded pixel, as the parser sees it
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] count;    // run length, 1 for a literal pixel
      logic       is_run;   // count must be clipped against the pixels left
      logic       more;     // literal packet still has pixels after this one
   } pix_type;

endpackage

[rtl/trpd_front.sv]
// ============================================================================
// trpd_front - byte parser
// Tracks packet headers and byte position, assembles pixels and pushes one
// record per completed pixel.
// ============================================================================
module trpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [2:0]       bytes_per_pixel,
   input  logic             rle_mode,
   input  logic             byte_valid,
   input  logic [7:0]       data_byte,
   output logic             push,
   output trpd_pkg::pix_type push_data
);

   logic       awaiting_ff, awaiting_in;
   logic       run_ff, run_in;
   logic [7:0] left_ff, left_in;
   logic [1:0] pos_ff, pos_in;
   logic [7:0] bytes_ff [3];
   logic       four;
   logic [1:0] last_pos;
   logic [7:0] left_dec;

   assign four     = (bytes_per_pixel == trpd_pkg::BPP_FOUR);
   assign last_pos = four ? 2'd3 : 2'd2;
   assign left_dec = left_ff - 8'd1;

   always_comb begin
      awaiting_in = awaiting_ff;
      run_in      = run_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      push        = 1'b0;
      push_data.blue   = bytes_ff[0];
      push_data.green  = bytes_ff[1];
      push_data.red    = four ? bytes_ff[2] : data_byte;
      push_data.alpha  = four ? data_byte : 8'd0;
      push_data.count  = 8'd1;
      push_data.is_run = 1'b0;
      push_data.more   = 1'b0;
      if (byte_valid) begin
         priority if (rle_mode && awaiting_ff) begin
            // header: start a literal packet or a run
            if (data_byte < trpd_pkg::RUN_FLAG_HDR) begin
               run_in  = 1'b0;
               left_in = data_byte + 8'd1;
            end else begin
               run_in  = 1'b1;
               left_in = data_byte - trpd_pkg::RUN_BIAS;
            end
            awaiting_in = 1'b0;
            pos_in      = 2'd0;
         end else if (pos_ff < last_pos) begin
            pos_in = pos_ff + 2'd1;
         end else begin
            push   = 1'b1;
            pos_in = 2'd0;
            if (rle_mode && run_ff) begin
               push_data.count  = left_ff;
               push_data.is_run = 1'b1;
               left_in          = 8'd0;
               awaiting_in      = 1'b1;
            end else if (rle_mode) begin
               left_in        = left_dec;
               push_data.more = (left_dec != 8'd0);
               if (left_dec == 8'd0) begin
                  awaiting_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         awaiting_ff <= 1'b1;
         run_ff      <= 1'b0;
         left_ff     <= 8'd0;
         pos_ff      <= 2'd0;
      end else begin
         awaiting_ff <= awaiting_in;
         run_ff      <= run_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
      end
   end

   // pixel byte store, written only while a pixel is being assembled
   always_ff @(posedge clock) begin
      if (byte_valid && !(rle_mode && awaiting_ff) && (pos_ff < last_pos)) begin
         bytes_ff[pos_ff] <= data_byte;
      end
   end

endmodule

[rtl/trpd_fifo.sv]
// ============================================================================
// trpd_fifo - pixel record queue
// Two-entry queue between the parser and the counter stage.
// ============================================================================
module trpd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  trpd_pkg::pix_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output trpd_pkg::pix_type pop_data
);

   localparam int unsigned CNT_W = $clog2(trpd_pkg::FIFO_DEPTH + 1);

   trpd_pkg::pix_type mem_ff [trpd_pkg::FIFO_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(trpd_pkg::FIFO_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/trpd_back.sv]
// ============================================================================
// trpd_back - pixel counter and output register
// Counts down the pixels left in the image, clips runs and literal packets
// at the image end, drops pixels after the end and holds the result.
// ============================================================================
module trpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [31:0]       total_in,
   input  logic              pix_valid,
   input  trpd_pkg::pix_type pix,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output trpd_pkg::pix_type out_pix,
   output logic              out_complete
);

   logic [31:0]       rem_ff, rem_in;
   logic              fin_ff, fin_in;
   logic              valid_ff, valid_in;
   trpd_pkg::pix_type pix_ff, pix_in;
   logic              cmpl_ff, cmpl_in;
   logic              over;
   logic [7:0]        rep;
   logic [31:0]       rem_next;

   assign pop  = pix_valid && (!valid_ff || out_ready);
   assign over = pix.is_run && ({24'd0, pix.count} > rem_ff);
   assign rep  = pix.is_run ? (over ? rem_ff[7:0] : pix.count) : 8'd1;
   assign rem_next = rem_ff - {24'd0, rep};

   always_comb begin
      rem_in   = rem_ff;
      fin_in   = fin_ff;
      valid_in = valid_ff && !out_ready;
      pix_in   = pix_ff;
      cmpl_in  = cmpl_ff;
      if (pop) begin
         if (fin_ff) begin
            // image done: drop the pixel
            valid_in = 1'b0;
         end else begin
            rem_in       = rem_next;
            fin_in       = (rem_next == 32'd0);
            valid_in     = 1'b1;
            pix_in       = pix;
            pix_in.count = rep;
            pix_in.more  = pix.is_run ? over : ((rem_next == 32'd0) && pix.more);
            cmpl_in      = (rem_next == 32'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 32'd1;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else if (restart) begin
         rem_ff   <= total_in;
         fin_ff   <= (total_in == 32'd0);
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         fin_ff   <= fin_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      cmpl_ff <= cmpl_in;
   end

   assign out_valid    = valid_ff;
   assign out_pix      = pix_ff;
   assign out_complete = cmpl_ff;

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// ============================================================================
// tga_rle_pixel_decoder - run-length decoder for truecolor image data
// Turns the image-data byte stream into RGB(A) pixels and run items.
// ============================================================================
// Usage:
//   req_* carries one image-data byte per transfer (after header and ID).
//   rsp_* carries one decoded item per transfer: a literal pixel with repeat
//   count 1, or a whole run with its repeat count. rsp_tlast marks the item
//   that reaches the last pixel of the image; rsp_tuser flags a packet that
//   ran past the image end and was cut there. Later bytes produce nothing.
//   csr_* writes bytes_per_pixel (0), rle_mode (1) and pixel_total (2);
//   any write to one of these restarts decoding at a packet header.
// Timing:
//   The byte parser takes one byte every cycle unless the pixel queue is full.
//   Header and partial pixel bytes give no item; the last byte of a pixel
//   gives an item on rsp_* via the pixel queue and the output register.
// Reset and stall:
//   Reset sets 3-byte pixels, run-length mode and a one-pixel image.
//   A stalled rsp_tready holds the output register; the parser keeps going
//   until the two-entry pixel queue is full, then req_tready drops.
// ============================================================================
module tga_rle_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // pixel output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] repeat_count
   output logic        rsp_tlast,   // image_complete
   output logic [0:0]  rsp_tuser,   // [0] clipped
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [2:0]        bpp_ff;
   logic              rle_ff;
   logic [31:0]       total_ff, total_in;
   logic              restart;
   logic              byte_valid;
   logic              push, fifo_full, fifo_valid, pop;
   trpd_pkg::pix_type push_data, fifo_data, out_pix;
   logic              out_complete;

   // Any write to a known register restarts both halves
   assign restart  = csr_we && (csr_index != trpd_pkg::REG_UNUSED);
   assign total_in = (csr_we && csr_index == trpd_pkg::REG_PIXEL_TOTAL) ? csr_data : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= 3'd3;
         rle_ff   <= 1'b1;
         total_ff <= 32'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            trpd_pkg::REG_BYTES_PER_PIXEL: bpp_ff <= csr_data[2:0];
            trpd_pkg::REG_RLE_MODE:        rle_ff <= csr_data[0];
            trpd_pkg::REG_PIXEL_TOTAL:     total_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Hold input while the queue cannot take a pixel
   assign req_tready = !fifo_full;
   assign byte_valid = req_tvalid && req_tready;

   trpd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (restart),
      .bytes_per_pixel (bpp_ff),
      .rle_mode        (rle_ff),
      .byte_valid      (byte_valid),
      .data_byte       (req_tdata),
      .push            (push),
      .push_data       (push_data)
   );

   trpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset || restart),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_valid (fifo_valid),
      .pop_data  (fifo_data)
   );

   trpd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .total_in     (total_in),
      .pix_valid    (fifo_valid),
      .pix          (fifo_data),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_pix      (out_pix),
      .out_complete (out_complete)
   );

   assign rsp_tdata = {out_pix.count, out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};
   assign rsp_tlast = out_complete;
   assign rsp_tuser = out_pix.more;

   // Every item covers at least one pixel
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:32] != 8'd0))
      else $error("zero repeat count on output");

   // A clipped packet always ends the image
   a_clip_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("clipped item without image end");

   // Nothing follows the last pixel of the image
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("item after image end");

endmodule
